/* rtl/swdm_pkg.sv */
// Shared constants for the stack with delete-middle block.
// Command and status codes, field widths and the default stack depth.
// No dependencies.
package swdm_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int VALUE_W       = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int LEVEL_W       = 8;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* rtl/swdm_intf.sv */
// Valid/ready channel interfaces for command and response transfers.
// Depends on swdm_pkg for field widths.
interface swdm_req_intf;
   logic                                valid;
   logic                                ready;
   logic [swdm_pkg::CMD_W-1:0]          cmd;
   logic signed [swdm_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, cmd, push_value, input ready);
   modport sink   (input valid, cmd, push_value, output ready);
endinterface

interface swdm_rsp_intf;
   logic                                valid;
   logic                                ready;
   logic signed [swdm_pkg::VALUE_W-1:0] out_value;
   logic [swdm_pkg::STATUS_W-1:0]       status;
   logic [swdm_pkg::LEVEL_W-1:0]        level;

   modport source (output valid, out_value, status, level, input ready);
   modport sink   (input valid, out_value, status, level, output ready);
endinterface

/* rtl/swdm_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module swdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stack_with_delete_middle_top.sv */
// Top level of the LIFO stack with push, pop and delete-middle commands.
// Depends on swdm_pkg, swdm_req_intf, swdm_rsp_intf and swdm_ram.
//
// Usage: commands arrive on req_chan (cmd, push_value) and each one yields
// exactly one transfer on rsp_chan (out_value, status, level). A transfer
// happens on a rising clock edge with valid and ready both high.
// The block handles one command at a time; req_chan.ready is high only while
// the sequencer is idle. Element storage is a single-port-read,
// single-port-write RAM with registered read data, and every step of a
// command goes through that one read port and one write port.
// Push, the unused code, and pop or delete on an empty stack go from the
// execute state straight to the response state. Pop first captures the top
// element read from the RAM. Delete-middle on a stack of n elements captures
// the element at position n-1-floor(n/2), then shifts the floor(n/2)
// elements above it down one at a time before the response.
// A new command is taken the cycle after a response is loaded into the
// output register, even if that response is still waiting. If the receiver
// stalls with a response pending, the next finished response waits in the
// sequencer until the output register frees.
// Synchronous reset empties the stack and drops any pending response; the
// RAM contents are not cleared and need no clearing pass.
module stack_with_delete_middle_top #(
   parameter int DEPTH = swdm_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   swdm_req_intf.sink   req_chan,
   swdm_rsp_intf.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int VW = swdm_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_CAP,
      S_DEL_CAP,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [swdm_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VW-1:0]                   value_ff, value_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [AW-1:0]                   idx_ff, idx_in;
   logic [VW-1:0]                   res_val_ff, res_val_in;
   logic [swdm_pkg::STATUS_W-1:0]   res_st_ff, res_st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                   rsp_val_ff, rsp_val_in;
   logic [swdm_pkg::STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [swdm_pkg::LEVEL_W-1:0]    rsp_lvl_ff, rsp_lvl_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [VW-1:0] mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [VW-1:0] mem_rd_data;

   logic [CW:0]   count_x;
   logic [CW:0]   idx_p1;
   logic [CW:0]   idx_p2;
   logic [CW-1:0] del_pos;
   logic          out_free;

   assign count_x  = {1'b0, count_ff};
   assign idx_p1   = {{(CW + 1 - AW){1'b0}}, idx_ff} + (CW + 1)'(1);
   assign idx_p2   = {{(CW + 1 - AW){1'b0}}, idx_ff} + (CW + 1)'(2);
   assign del_pos  = count_ff - CW'(1) - (count_ff >> 1);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               value_in = req_chan.push_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_val_in = '0;
            res_st_in  = swdm_pkg::ST_OK;
            state_in   = S_RESP;
            unique case (cmd_ff)
               swdm_pkg::CMD_PUSH: begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_st_in = swdm_pkg::ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(count_ff);
                     mem_wr_data = value_ff;
                     count_in    = count_ff + CW'(1);
                  end
               end
               swdm_pkg::CMD_POP: begin
                  if (count_ff == '0) begin
                     res_val_in = '1;
                     res_st_in  = swdm_pkg::ST_EMPTY;
                  end else begin
                     mem_rd_addr = AW'(count_ff - CW'(1));
                     count_in    = count_ff - CW'(1);
                     state_in    = S_POP_CAP;
                  end
               end
               swdm_pkg::CMD_DEL: begin
                  if (count_ff == '0) begin
                     res_val_in = '1;
                     res_st_in  = swdm_pkg::ST_EMPTY;
                  end else begin
                     mem_rd_addr = AW'(del_pos);
                     idx_in      = AW'(del_pos);
                     state_in    = S_DEL_CAP;
                  end
               end
               swdm_pkg::CMD_NONE: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_POP_CAP: begin
            res_val_in = mem_rd_data;
            state_in   = S_RESP;
         end
         S_DEL_CAP: begin
            res_val_in = mem_rd_data;
            if (idx_p1 < count_x) begin
               mem_rd_addr = AW'(idx_p1);
               state_in    = S_SHIFT;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            mem_wr_en = 1'b1;
            if (idx_p2 < count_x) begin
               mem_rd_addr = AW'(idx_p2);
               idx_in      = AW'(idx_p1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               rsp_lvl_in   = swdm_pkg::LEVEL_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      idx_ff     <= idx_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_lvl_ff <= rsp_lvl_in;
   end

   swdm_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_value = rsp_val_ff;
   assign rsp_chan.status    = rsp_st_ff;
   assign rsp_chan.level     = rsp_lvl_ff;

endmodule

/* rtl/swdm_checker.sv */
// Port-level checks for the stack with delete-middle block, bound to its top.
// Depends on swdm_pkg and stack_with_delete_middle_top.
module swdm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [swdm_pkg::VALUE_W-1:0]        rsp_out_value,
   input logic [swdm_pkg::STATUS_W-1:0]       rsp_status,
   input logic [swdm_pkg::LEVEL_W-1:0]        rsp_level
);

   // An empty response always carries all ones and a zero level.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swdm_pkg::ST_EMPTY |->
         rsp_out_value == '1 && rsp_level == '0)
      else $error("empty response with wrong value or level");

   // A dropped push returns zero.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swdm_pkg::ST_FULL |-> rsp_out_value == '0)
      else $error("full response with nonzero value");

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_value) && $stable(rsp_status)
         && $stable(rsp_level))
      else $error("stalled response changed");

   // A command is taken only when no transfer is still being worked on:
   // the cycle after a command transfer the block is busy.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after a command transfer");

endmodule

bind stack_with_delete_middle_top swdm_checker u_swdm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_value (rsp_chan.out_value),
   .rsp_status    (rsp_chan.status),
   .rsp_level     (rsp_chan.level)
);

/* bench/tb_stack_with_delete_middle_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stack_with_delete_middle_top: push, pop and delete-middle commands
// go in, and every response is checked against a shadow stack kept in the bench.
// Depends on swdm_pkg, swdm_req_intf, swdm_rsp_intf and the block's RTL.
module tb_stack_with_delete_middle_top;

   localparam int STACK_DEPTH = swdm_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 100;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [swdm_pkg::CMD_W-1:0]          cmd;
      logic signed [swdm_pkg::VALUE_W-1:0] value;
      bit                                  hold;
   } stack_cmd_type;

   typedef struct {
      logic signed [swdm_pkg::VALUE_W-1:0] out_value;
      logic [swdm_pkg::STATUS_W-1:0]       status;
      logic [swdm_pkg::LEVEL_W-1:0]        level;
   } stack_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                drv_valid = 1'b0;
   logic [swdm_pkg::CMD_W-1:0]          drv_cmd = swdm_pkg::CMD_PUSH;
   logic signed [swdm_pkg::VALUE_W-1:0] drv_value = '0;
   logic                                drv_ready = 1'b0;
   logic                                req_taken = 1'b0;

   swdm_req_intf req_if ();
   swdm_rsp_intf rsp_if ();

   assign req_if.valid      = drv_valid;
   assign req_if.cmd        = drv_cmd;
   assign req_if.push_value = drv_value;
   assign rsp_if.ready      = drv_ready;

   stack_with_delete_middle_top #(.DEPTH(STACK_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   stack_cmd_type pending_cmds[$];
   stack_rsp_type expected_rsps[$];

   logic signed [swdm_pkg::VALUE_W-1:0] shadow_mem [STACK_DEPTH];
   int shadow_fill = 0;

   int tx_idle_pct = 36;
   int rx_idle_pct = 86;
   int queued_total = 0;
   int accepted_total = 0;
   int gen_level = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int rsp_checked = 0;
   int cmd_counts [4] = '{0, 0, 0, 0};
   int full_count = 0;
   int empty_count = 0;
   int peak_level = 0;

   // Applies one command to the shadow stack and returns the response it must produce.
   function automatic stack_rsp_type apply_command(
      input logic [swdm_pkg::CMD_W-1:0] cmd,
      input logic signed [swdm_pkg::VALUE_W-1:0] value);
      stack_rsp_type r;
      int pos;
      r.out_value = '0;
      r.status = swdm_pkg::ST_OK;
      case (cmd)
         swdm_pkg::CMD_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               r.status = swdm_pkg::ST_FULL;
            end else begin
               shadow_mem[shadow_fill] = value;
               shadow_fill++;
            end
         end
         swdm_pkg::CMD_POP: begin
            if (shadow_fill == 0) begin
               r.out_value = -1;
               r.status = swdm_pkg::ST_EMPTY;
            end else begin
               shadow_fill--;
               r.out_value = shadow_mem[shadow_fill];
            end
         end
         swdm_pkg::CMD_DEL: begin
            if (shadow_fill == 0) begin
               r.out_value = -1;
               r.status = swdm_pkg::ST_EMPTY;
            end else begin
               pos = shadow_fill - 1 - shadow_fill / 2;
               r.out_value = shadow_mem[pos];
               for (int i = pos; i < shadow_fill - 1; i++)
                  shadow_mem[i] = shadow_mem[i + 1];
               shadow_fill--;
            end
         end
         default: begin
         end
      endcase
      r.level = shadow_fill[swdm_pkg::LEVEL_W-1:0];
      return r;
   endfunction

   function automatic logic signed [swdm_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_command(input logic [swdm_pkg::CMD_W-1:0] cmd,
                                input logic signed [swdm_pkg::VALUE_W-1:0] value,
                                input bit hold);
      stack_cmd_type item;
      item.cmd = cmd;
      item.value = value;
      item.hold = hold;
      pending_cmds.push_back(item);
      queued_total++;
      if (cmd == swdm_pkg::CMD_PUSH && gen_level < STACK_DEPTH)
         gen_level++;
      else if ((cmd == swdm_pkg::CMD_POP || cmd == swdm_pkg::CMD_DEL) && gen_level > 0)
         gen_level--;
   endtask

   task automatic queue_random_mix(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 48)
            queue_command(swdm_pkg::CMD_PUSH, pick_value(), i == count / 2);
         else if (r < 70)
            queue_command(swdm_pkg::CMD_POP, pick_value(), i == count / 2);
         else if (r < 95)
            queue_command(swdm_pkg::CMD_DEL, pick_value(), i == count / 2);
         else
            queue_command(swdm_pkg::CMD_NONE, pick_value(), i == count / 2);
      end
   endtask

   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (accepted_total != queued_total || expected_rsps.size() != 0);
   endtask

   always @(negedge clock) begin
      stack_cmd_type item;
      if (reset) begin
         drv_valid <= 1'b0;
         drv_ready <= 1'b0;
      end else begin
         drv_ready <= ($urandom_range(99) >= rx_idle_pct);
         if (!drv_valid || req_taken) begin
            if (pending_cmds.size() == 0 ||
                (pending_cmds[0].hold && expected_rsps.size() != 0) ||
                $urandom_range(99) < tx_idle_pct) begin
               drv_valid <= 1'b0;
            end else begin
               item = pending_cmds.pop_front();
               drv_valid <= 1'b1;
               drv_cmd <= item.cmd;
               drv_value <= item.value;
            end
         end
      end
   end

   always @(posedge clock) begin
      stack_rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("tb_stack_with_delete_middle_top: done, errors");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            want = apply_command(req_if.cmd, req_if.push_value);
            expected_rsps.push_back(want);
            accepted_total++;
            cmd_counts[req_if.cmd]++;
            if (want.status == swdm_pkg::ST_FULL)
               full_count++;
            if (want.status == swdm_pkg::ST_EMPTY)
               empty_count++;
            if (shadow_fill > peak_level)
               peak_level = shadow_fill;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected response: value %0d status %0d level %0d",
                           $realtime, rsp_if.out_value, rsp_if.status, rsp_if.level);
            end else begin
               want = expected_rsps.pop_front();
               rsp_checked++;
               if (rsp_if.out_value !== want.out_value || rsp_if.status !== want.status ||
                   rsp_if.level !== want.level) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("%0t: response %0d expected value %0d status %0d level %0d",
                              $realtime, rsp_checked, want.out_value, want.status,
                              want.level);
                     $display("%0t: response %0d got value %0d status %0d level %0d",
                              $realtime, rsp_checked, rsp_if.out_value, rsp_if.status,
                              rsp_if.level);
                  end
               end
            end
         end
      end
   end

   initial begin
      queue_command(swdm_pkg::CMD_POP, 0, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_NONE, 32'sh7FFF_FFFF, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, 32'sh7FFF_FFFF, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, 32'sh8000_0000, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, -1, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, 0, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, 32'sh5A5A_A5A5, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_NONE, -1, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_POP, -1, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_POP, 0, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_random_mix(80);
      wait_until_drained();

      tx_idle_pct = 86;
      rx_idle_pct = 36;
      queue_random_mix(80);
      wait_until_drained();

      // The stack is filled past its depth, worked at the top end, then emptied.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_command(swdm_pkg::CMD_PUSH, pick_value(), 1'b1);
      while (gen_level < STACK_DEPTH)
         queue_command(swdm_pkg::CMD_PUSH, pick_value(), 1'b0);
      repeat (3) queue_command(swdm_pkg::CMD_PUSH, pick_value(), 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, pick_value(), 1'b0);
      queue_command(swdm_pkg::CMD_PUSH, pick_value(), 1'b0);
      queue_command(swdm_pkg::CMD_POP, 0, 1'b0);
      queue_command(swdm_pkg::CMD_NONE, 0, 1'b0);
      queue_random_mix(20);
      while (gen_level > 0)
         queue_command($urandom_range(1) ? swdm_pkg::CMD_DEL : swdm_pkg::CMD_POP,
                       pick_value(), 1'b0);
      queue_command(swdm_pkg::CMD_POP, 0, 1'b0);
      queue_command(swdm_pkg::CMD_DEL, 0, 1'b0);
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         mismatch_count += expected_rsps.size();
         $display("%0d responses never arrived", expected_rsps.size());
      end
      $display("Ran %0d commands (%0d push, %0d pop, %0d delete, %0d unused) in %0d cycles.",
               accepted_total, cmd_counts[swdm_pkg::CMD_PUSH], cmd_counts[swdm_pkg::CMD_POP],
               cmd_counts[swdm_pkg::CMD_DEL], cmd_counts[swdm_pkg::CMD_NONE], cycle_count);
      $display("Checked %0d responses; peak level %0d, %0d full and %0d empty hits.",
               rsp_checked, peak_level, full_count, empty_count);
      if (mismatch_count == 0)
         $display("tb_stack_with_delete_middle_top: done, clean");
      else
         $display("tb_stack_with_delete_middle_top: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/swdm_pkg.sv
rtl/swdm_intf.sv
rtl/swdm_ram.sv
rtl/stack_with_delete_middle_top.sv
rtl/swdm_checker.sv
bench/tb_stack_with_delete_middle_top.sv
